[sv/trd_pkg.sv]
`default_nettype none
package trd_pkg;

  localparam int unsigned CoordW      = 12;
  localparam int unsigned ProdW       = 2 * CoordW;
  localparam int unsigned PosOutW     = 25;
  localparam int unsigned KindW       = 2;
  localparam int unsigned PressW      = 8;
  localparam int unsigned TrackW      = 4;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 12;

  localparam int unsigned MaxPointsDef  = 10;
  localparam int unsigned FrameBytesDef = 63;
  localparam int unsigned SingleBytes   = 7;

  localparam int unsigned MulSteps = CoordW;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned SclCntW  = $clog2(DivSteps);

  localparam logic [PressW-1:0] PointPressure = 8'd200;
  localparam logic [3:0]        NibbleMask    = 4'hF;

  localparam logic              MultiRst  = 1'b1;
  localparam logic              LayoutRst = 1'b0;
  localparam logic              SwapRst   = 1'b0;
  localparam logic              ScaleRst  = 1'b0;
  localparam logic [CoordW-1:0] ScrWRst   = 12'd800;
  localparam logic [CoordW-1:0] ScrHRst   = 12'd1280;
  localparam logic [CoordW-1:0] PnlWRst   = 12'd800;
  localparam logic [CoordW-1:0] PnlHRst   = 12'd1280;

  typedef enum logic [KindW-1:0] {
    KIND_POINT   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_KEY     = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MULTI   = 3'd0,
    CFG_LAYOUT  = 3'd1,
    CFG_SWAP    = 3'd2,
    CFG_SCALE   = 3'd3,
    CFG_SCR_W   = 3'd4,
    CFG_SCR_H   = 3'd5,
    CFG_PNL_W   = 3'd6,
    CFG_PNL_H   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LOAD
  } trd_state_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV
  } scl_state_e;

endpackage
`default_nettype wire

[sv/trd_scaler.sv]
`default_nettype none
module trd_scaler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [trd_pkg::CoordW:0]      value_i,
  input  logic        [trd_pkg::CoordW-1:0]    mul_i,
  input  logic        [trd_pkg::CoordW-1:0]    div_i,
  output logic                                 done_o,
  output logic signed [trd_pkg::PosOutW-1:0]   result_o
);
  import trd_pkg::*;

  scl_state_e          state_q, state_d;
  logic [SclCntW-1:0]  cnt_q, cnt_d;
  logic [CoordW-1:0]   mcand_q, mcand_d;
  logic                neg_q, neg_d;
  logic [CoordW-1:0]   mhi_q, mhi_d;
  logic [CoordW-1:0]   mlo_q, mlo_d;
  logic [CoordW-1:0]   rem_q, rem_d;
  logic [ProdW-1:0]    dq_q, dq_d;
  logic [ProdW-1:0]    res_q, res_d;
  logic                done_q, done_d;

  logic [CoordW:0]     msum;
  logic [CoordW:0]     dsh;
  logic [CoordW:0]     drem;
  logic                dge;
  logic [ProdW-1:0]    dq_next;
  logic [CoordW:0]     abs_val;

  always_comb begin
    abs_val = value_i[CoordW] ? (CoordW+1)'(-value_i) : value_i;
    msum    = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, mcand_q} : '0);
    dsh     = {rem_q, dq_q[ProdW-1]};
    dge     = (dsh >= {1'b0, div_i});
    drem    = dge ? (dsh - {1'b0, div_i}) : dsh;
    dq_next = {dq_q[ProdW-2:0], dge};

    state_d = state_q;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    neg_d   = neg_q;
    mhi_d   = mhi_q;
    mlo_d   = mlo_q;
    rem_d   = rem_q;
    dq_d    = dq_q;
    res_d   = res_q;
    done_d  = 1'b0;

    case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          mcand_d = abs_val[CoordW-1:0];
          neg_d   = value_i[CoordW];
          mhi_d   = '0;
          mlo_d   = mul_i;
          cnt_d   = '0;
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        // shift-add, one multiplier bit per cycle
        mhi_d = msum[CoordW:1];
        mlo_d = {msum[0], mlo_q[CoordW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SclCntW'(MulSteps - 1)) begin
          dq_d    = {msum, mlo_q[CoordW-1:1]};
          rem_d   = '0;
          cnt_d   = '0;
          state_d = SC_DIV;
        end
      end
      SC_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_d = drem[CoordW-1:0];
        dq_d  = dq_next;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SclCntW'(DivSteps - 1)) begin
          res_d   = (div_i == '0) ? '0 : dq_next;
          done_d  = 1'b1;
          cnt_d   = '0;
          state_d = SC_IDLE;
        end
      end
      default: begin
        state_d = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    neg_q   <= neg_d;
    mhi_q   <= mhi_d;
    mlo_q   <= mlo_d;
    rem_q   <= rem_d;
    dq_q    <= dq_d;
    res_q   <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = neg_q ? -$signed({1'b0, res_q}) : $signed({1'b0, res_q});

endmodule
`default_nettype wire

[sv/touch_report_decode_and_map_unit.sv]
// channel  | handshake                | payload
// ---------+--------------------------+----------------------------------------------
// in       | in_valid_i / in_stall_o  | data_byte_i, frame_start_i
// out      | out_valid_o / out_stall_i| kind_o, pos_x_o, pos_y_o, pressure_o,
//          |                          | tracking_id_o, touch_key_o, last_o
// cfg      | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// A byte that gives no result does not stall the input; one that gives an unscaled result goes via ST_LOAD.
// A point with scaling on goes through ST_SCALE: the x and y serial scalers run in
// parallel, each a 12-step multiply then a 24-step divide, one bit per cycle.
// Reset clears frame counters, state and output valid, and loads register defaults.
// in_stall_o is high while an item is in work; out stall only holds the output
// register and stops a new result from loading.
`default_nettype none
module touch_report_decode_and_map_unit #(
  parameter int unsigned MAX_POINTS  = trd_pkg::MaxPointsDef,
  parameter int unsigned FRAME_BYTES = trd_pkg::FrameBytesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                frame_start_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [trd_pkg::KindW-1:0]           kind_o,
  output logic signed [trd_pkg::PosOutW-1:0]  pos_x_o,
  output logic signed [trd_pkg::PosOutW-1:0]  pos_y_o,
  output logic [trd_pkg::PressW-1:0]          pressure_o,
  output logic [trd_pkg::TrackW-1:0]          tracking_id_o,
  output logic                                touch_key_o,
  output logic                                last_o,
  input  logic                                cfg_we_i,
  input  logic [trd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [trd_pkg::CfgDataW-1:0]        cfg_data_i
);
  import trd_pkg::*;

  localparam int unsigned BytePosW = $clog2(FRAME_BYTES + 1);

  // registers
  logic              multi_q, layout_q, swap_q, scale_q;
  logic [CoordW-1:0] scr_w_q, scr_h_q, pnl_w_q, pnl_h_q;

  // frame state
  logic [BytePosW-1:0] pos_q, pos_d;
  logic [3:0]          total_q, total_d;
  logic                active_q, active_d;
  logic [2:0]          off_q, off_d;
  logic [TrackW-1:0]   idx_q, idx_d;
  logic [CoordW-1:0]   raw_x_q, raw_x_d;
  logic [3:0]          yhn_q, yhn_d;

  // item in work
  trd_state_e               state_q, state_d;
  kind_e                    rkind_q, rkind_d;
  logic [TrackW-1:0]        rid_q, rid_d;
  logic                     rkey_q, rkey_d;
  logic                     rlast_q, rlast_d;
  logic                     rmulti_q, rmulti_d;
  logic signed [CoordW:0]   val_x_q, val_x_d;
  logic signed [CoordW:0]   val_y_q, val_y_d;
  logic signed [PosOutW-1:0] xs_q, xs_d;
  logic signed [PosOutW-1:0] ys_q, ys_d;

  // output register
  logic                      ovalid_q, ovalid_d;
  kind_e                     okind_q, okind_d;
  logic signed [PosOutW-1:0] opx_q, opx_d;
  logic signed [PosOutW-1:0] opy_q, opy_d;
  logic [PressW-1:0]         opr_q, opr_d;
  logic [TrackW-1:0]         oid_q, oid_d;
  logic                      okey_q, okey_d;
  logic                      olast_q, olast_d;

  logic                      accept;
  logic [BytePosW-1:0]       pos_n;
  logic [BytePosW-1:0]       limit;
  logic [2:0]                off_cur;
  logic [TrackW-1:0]         idx_cur;
  logic [CoordW-1:0]         py;
  logic signed [CoordW:0]    first_x;
  logic                      hit;
  logic                      scl_start;
  logic                      done_x, done_y;
  logic signed [PosOutW-1:0] scl_x, scl_y;
  logic signed [PosOutW-1:0] fin_x;
  logic                      load;

  trd_scaler u_scl_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scl_start),
    .value_i  (val_x_d),
    .mul_i    (scr_w_q),
    .div_i    (pnl_w_q),
    .done_o   (done_x),
    .result_o (scl_x)
  );

  trd_scaler u_scl_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scl_start),
    .value_i  (val_y_d),
    .mul_i    (scr_h_q),
    .div_i    (pnl_h_q),
    .done_o   (done_y),
    .result_o (scl_y)
  );

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    pos_n   = pos_q + 1'b1;
    limit   = multi_q ? BytePosW'(FRAME_BYTES) : BytePosW'(SingleBytes);
    py      = {yhn_q, data_byte_i};
    first_x = (multi_q && !layout_q)
              ? ($signed({1'b0, scr_w_q}) - $signed({1'b0, raw_x_q}))
              : $signed({1'b0, raw_x_q});
    if (pos_n == BytePosW'(3)) begin
      off_cur = '0;
      idx_cur = '0;
    end else if (off_q == 3'd5) begin
      off_cur = '0;
      idx_cur = idx_q + 1'b1;
    end else begin
      off_cur = off_q + 1'b1;
      idx_cur = idx_q;
    end

    pos_d    = pos_q;
    total_d  = total_q;
    active_d = active_q;
    off_d    = off_q;
    idx_d    = idx_q;
    raw_x_d  = raw_x_q;
    yhn_d    = yhn_q;
    hit      = 1'b0;
    rkind_d  = rkind_q;
    rid_d    = rid_q;
    rkey_d   = rkey_q;
    rlast_d  = rlast_q;
    rmulti_d = rmulti_q;
    val_x_d  = val_x_q;
    val_y_d  = val_y_q;

    if (accept) begin
      if (frame_start_i) begin
        pos_d    = '0;
        total_d  = '0;
        active_d = 1'b1;
      end else if (active_q) begin
        pos_d = pos_n;
        if (pos_n >= limit) begin
          active_d = 1'b0;
        end else begin
          if (pos_n == BytePosW'(2)) begin
            total_d = data_byte_i[3:0] & NibbleMask;
            rid_d   = '0;
            rlast_d = 1'b1;
            rkey_d  = 1'b0;
            if (data_byte_i[3:0] == 4'd0) begin
              hit      = 1'b1;
              rkind_d  = KIND_RELEASE;
              active_d = 1'b0;
            end else if (multi_q && (data_byte_i[3:0] > 4'(MAX_POINTS))) begin
              hit      = 1'b1;
              rkind_d  = KIND_INVALID;
              active_d = 1'b0;
            end else if (!multi_q && (data_byte_i[3:0] != 4'd1)) begin
              hit      = 1'b1;
              rkind_d  = KIND_KEY;
              rkey_d   = 1'b1;
              active_d = 1'b0;
            end
          end else if (pos_n >= BytePosW'(3)) begin
            off_d = off_cur;
            idx_d = idx_cur;
            case (off_cur)
              3'd0: raw_x_d = {data_byte_i[3:0], 8'd0};
              3'd1: raw_x_d = {raw_x_q[CoordW-1:8], data_byte_i};
              3'd2: yhn_d   = data_byte_i[3:0];
              3'd3: begin
                if (idx_cur < total_q) begin
                  if (swap_q) begin
                    val_x_d = $signed({1'b0, py});
                    val_y_d = first_x;
                  end else begin
                    val_x_d = first_x;
                    val_y_d = $signed({1'b0, py});
                  end
                  rkind_d  = KIND_POINT;
                  rmulti_d = multi_q;
                  if (multi_q) begin
                    hit     = 1'b1;
                    rid_d   = idx_cur;
                    rkey_d  = 1'b0;
                    rlast_d = (idx_cur + 1'b1 == total_q);
                    if (idx_cur + 1'b1 == total_q) begin
                      active_d = 1'b0;
                    end
                  end else if ((total_q == 4'd1) && (idx_cur == '0)) begin
                    hit      = 1'b1;
                    rid_d    = '0;
                    rkey_d   = 1'b1;
                    rlast_d  = 1'b1;
                    active_d = 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
          if (({1'b0, pos_n} + 1'b1) >= {1'b0, limit}) begin
            active_d = 1'b0;
          end
        end
      end
    end
  end

  // control of the item in work and the output register
  always_comb begin
    state_d   = state_q;
    scl_start = 1'b0;
    xs_d      = xs_q;
    ys_d      = ys_q;
    load      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (hit) begin
          xs_d = PosOutW'(val_x_d);
          ys_d = PosOutW'(val_y_d);
          if ((rkind_d == KIND_POINT) && scale_q) begin
            scl_start = 1'b1;
            state_d   = ST_SCALE;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_SCALE: begin
        if (done_x && done_y) begin
          xs_d    = scl_x;
          ys_d    = scl_y;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!ovalid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    fin_x = layout_q ? xs_q : ($signed(PosOutW'(scr_w_q)) - xs_q);

    ovalid_d = ovalid_q && out_stall_i;
    okind_d  = okind_q;
    opx_d    = opx_q;
    opy_d    = opy_q;
    opr_d    = opr_q;
    oid_d    = oid_q;
    okey_d   = okey_q;
    olast_d  = olast_q;
    if (load) begin
      ovalid_d = 1'b1;
      okind_d  = rkind_q;
      oid_d    = rid_q;
      okey_d   = rkey_q;
      olast_d  = rlast_q;
      if (rkind_q == KIND_POINT) begin
        opr_d = PointPressure;
        if (rmulti_q) begin
          opx_d = $signed(PosOutW'(scr_h_q)) - ys_q;
          opy_d = fin_x;
        end else begin
          opx_d = xs_q;
          opy_d = ys_q;
        end
      end else begin
        opr_d = '0;
        opx_d = '0;
        opy_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multi_q  <= MultiRst;
      layout_q <= LayoutRst;
      swap_q   <= SwapRst;
      scale_q  <= ScaleRst;
      scr_w_q  <= ScrWRst;
      scr_h_q  <= ScrHRst;
      pnl_w_q  <= PnlWRst;
      pnl_h_q  <= PnlHRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MULTI:  multi_q  <= cfg_data_i[0];
        CFG_LAYOUT: layout_q <= cfg_data_i[0];
        CFG_SWAP:   swap_q   <= cfg_data_i[0];
        CFG_SCALE:  scale_q  <= cfg_data_i[0];
        CFG_SCR_W:  scr_w_q  <= cfg_data_i[CoordW-1:0];
        CFG_SCR_H:  scr_h_q  <= cfg_data_i[CoordW-1:0];
        CFG_PNL_W:  pnl_w_q  <= cfg_data_i[CoordW-1:0];
        CFG_PNL_H:  pnl_h_q  <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      total_q  <= '0;
      active_q <= 1'b0;
      off_q    <= '0;
      idx_q    <= '0;
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      total_q  <= total_d;
      active_q <= active_d;
      off_q    <= off_d;
      idx_q    <= idx_d;
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_x_q  <= raw_x_d;
    yhn_q    <= yhn_d;
    rkind_q  <= rkind_d;
    rid_q    <= rid_d;
    rkey_q   <= rkey_d;
    rlast_q  <= rlast_d;
    rmulti_q <= rmulti_d;
    val_x_q  <= val_x_d;
    val_y_q  <= val_y_d;
    xs_q     <= xs_d;
    ys_q     <= ys_d;
    okind_q  <= okind_d;
    opx_q    <= opx_d;
    opy_q    <= opy_d;
    opr_q    <= opr_d;
    oid_q    <= oid_d;
    okey_q   <= okey_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign kind_o        = okind_q;
  assign pos_x_o       = opx_q;
  assign pos_y_o       = opy_q;
  assign pressure_o    = opr_q;
  assign tracking_id_o = oid_q;
  assign touch_key_o   = okey_q;
  assign last_o        = olast_q;

endmodule
`default_nettype wire

[sv/trd_checker.sv]
`default_nettype none
module trd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [trd_pkg::KindW-1:0]           kind_o,
  input logic signed [trd_pkg::PosOutW-1:0]  pos_x_o,
  input logic signed [trd_pkg::PosOutW-1:0]  pos_y_o,
  input logic [trd_pkg::PressW-1:0]          pressure_o,
  input logic [trd_pkg::TrackW-1:0]          tracking_id_o,
  input logic                                touch_key_o,
  input logic                                last_o
);
  import trd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(pos_x_o)
      && $stable(pos_y_o) && $stable(tracking_id_o) && $stable(last_o))
    else $error("stalled output item changed");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output item dropped without being taken");

  a_non_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_POINT) |-> (pos_x_o == '0) && (pos_y_o == '0)
      && (pressure_o == '0) && (tracking_id_o == '0) && last_o
      && (touch_key_o == (kind_o == KIND_KEY)))
    else $error("frame status item carries point data");

  a_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_POINT) |-> (pressure_o == PointPressure)
      && (!touch_key_o || (last_o && (tracking_id_o == '0))))
    else $error("point item fields inconsistent");

endmodule

bind touch_report_decode_and_map_unit trd_checker u_trd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .pos_x_o       (pos_x_o),
  .pos_y_o       (pos_y_o),
  .pressure_o    (pressure_o),
  .tracking_id_o (tracking_id_o),
  .touch_key_o   (touch_key_o),
  .last_o        (last_o)
);
`default_nettype wire
